>>> sv/assert_macros.svh
// Assertion macros shared by the line follower RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property is checked at every rising clock edge outside of reset.
`define LFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The expression must never be true outside of reset.
`define LFS_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `LFS_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

>>> sv/lfs_pkg.sv
// Types and constants shared by the line follower step modules.
package lfs_pkg;

  localparam int unsigned REFL_W    = 7;
  localparam int unsigned DRIVE_W   = 8;
  localparam int unsigned GAIN_W    = 26;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned ERR_W     = 8;
  localparam int unsigned DIFF_W    = 9;

  // Integral magnitude entering the product is limited to 2^36.
  localparam int unsigned CLAMP_W = 37;
  localparam logic [CLAMP_W-1:0] CLAMP_MAG = 37'h10_0000_0000;

  // The integral product is split into a low and a high partial product.
  localparam int unsigned SPLIT_W   = 19;
  localparam int unsigned PROP_W    = GAIN_W + 1 + ERR_W;
  localparam int unsigned DERIV_W   = GAIN_W + 1 + DIFF_W;
  localparam int unsigned LO_W      = GAIN_W + SPLIT_W;
  localparam int unsigned HI_W      = GAIN_W + CLAMP_W - SPLIT_W;
  localparam int unsigned IMAG_W    = GAIN_W + CLAMP_W;
  localparam int unsigned TOTAL_W   = 64;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned UFULL_W   = TOTAL_W - FRAC_W;
  localparam int unsigned U_W       = 10;
  localparam int unsigned SUM_DRV_W = 11;

  // Any correction beyond this saturates both drives anyway.
  localparam logic signed [U_W-1:0]       U_LIMIT     = 10'sd255;
  localparam logic signed [SUM_DRV_W-1:0] DRIVE_LIMIT = 11'sd100;

  localparam logic [REFL_W-1:0] THRESHOLD_RST  = 7'd50;
  localparam logic [REFL_W-1:0] BASE_SPEED_RST = 7'd30;
  localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 26'd13107;
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 26'd13;
  localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 26'd3276800;

  // Pipeline stage positions.
  localparam int unsigned ST_IN   = 0;
  localparam int unsigned ST_PID  = 1;
  localparam int unsigned ST_MAG  = 2;
  localparam int unsigned ST_MUL  = 3;
  localparam int unsigned ST_TERM = 4;
  localparam int unsigned ST_SUM  = 5;
  localparam int unsigned ST_U    = 6;
  localparam int unsigned ST_OUT  = 7;
  localparam int unsigned STAGES  = 8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_BASE_SPEED = 3'd1,
    REG_GAIN_PROP  = 3'd2,
    REG_GAIN_INTEG = 3'd3,
    REG_GAIN_DERIV = 3'd4
  } lfs_reg_e;

  typedef struct packed {
    logic [REFL_W-1:0] threshold;
    logic [REFL_W-1:0] base_speed;
    logic [GAIN_W-1:0] gain_prop;
    logic [GAIN_W-1:0] gain_integ;
    logic [GAIN_W-1:0] gain_deriv;
  } lfs_cfg_t;

  // Per-stage load enables and valid flags of the pipeline.
  typedef struct packed {
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] valid;
  } lfs_pipe_t;

endpackage

>>> sv/lfs_cfg.sv
// Configuration register file of the line follower step.
module lfs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lfs_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lfs_pkg::GAIN_W-1:0]     cfg_data_i,
  output lfs_pkg::lfs_cfg_t              cfg_o
);
  import lfs_pkg::*;

  lfs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lfs_reg_e'(cfg_idx_i))
        REG_THRESHOLD:  cfg_d.threshold  = cfg_data_i[REFL_W-1:0];
        REG_BASE_SPEED: cfg_d.base_speed = cfg_data_i[REFL_W-1:0];
        REG_GAIN_PROP:  cfg_d.gain_prop  = cfg_data_i;
        REG_GAIN_INTEG: cfg_d.gain_integ = cfg_data_i;
        REG_GAIN_DERIV: cfg_d.gain_deriv = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= THRESHOLD_RST;
      cfg_q.base_speed <= BASE_SPEED_RST;
      cfg_q.gain_prop  <= GAIN_PROP_RST;
      cfg_q.gain_integ <= GAIN_INTEG_RST;
      cfg_q.gain_deriv <= GAIN_DERIV_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/lfs_front.sv
// Input register, PID state update and integral magnitude stages.
module lfs_front #(
  parameter int unsigned INTEGRAL_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfs_pkg::lfs_pipe_t                  pipe_i,
  input  lfs_pkg::lfs_cfg_t                   cfg_i,
  input  logic [lfs_pkg::REFL_W-1:0]          refl_left_i,
  input  logic [lfs_pkg::REFL_W-1:0]          refl_middle_i,
  input  logic [lfs_pkg::REFL_W-1:0]          refl_right_i,
  output logic signed [lfs_pkg::ERR_W-1:0]    err_o,
  output logic signed [lfs_pkg::DIFF_W-1:0]   diff_o,
  output logic [lfs_pkg::CLAMP_W-1:0]         mag_o,
  output logic                                neg_o,
  output logic                                junction_o
);
  import lfs_pkg::*;

  localparam int unsigned W    = INTEGRAL_WIDTH;
  localparam int unsigned MagW = (W > CLAMP_W) ? W : CLAMP_W;

  // Stage 1: registered samples.
  logic [REFL_W-1:0] left_q, mid_q, right_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[ST_IN]) begin
      left_q  <= refl_left_i;
      mid_q   <= refl_middle_i;
      right_q <= refl_right_i;
    end
  end

  // Stage 2: error, saturating integral and error difference.
  logic signed [ERR_W-1:0]  err_c;
  logic signed [W:0]        sum_ext;
  logic signed [W-1:0]      sum_sat;
  logic signed [DIFF_W-1:0] diff_c;
  logic                     junc_c;
  logic                     upd;
  logic signed [W-1:0]      integ_q;
  logic signed [ERR_W-1:0]  prev_q;

  assign err_c   = $signed({1'b0, mid_q}) - $signed({1'b0, cfg_i.threshold});
  assign sum_ext = {integ_q[W-1], integ_q} + {{(W-ERR_W+1){err_c[ERR_W-1]}}, err_c};
  assign diff_c  = {err_c[ERR_W-1], err_c} - {prev_q[ERR_W-1], prev_q};
  assign junc_c  = (left_q < cfg_i.threshold) && (right_q < cfg_i.threshold);
  assign upd     = pipe_i.load[ST_PID] && pipe_i.valid[ST_IN];

  always_comb begin
    if (sum_ext[W] != sum_ext[W-1]) begin
      sum_sat = sum_ext[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (upd) begin
      integ_q <= sum_sat;
      prev_q  <= err_c;
    end
  end

  logic signed [ERR_W-1:0]  err2_q;
  logic signed [DIFF_W-1:0] diff2_q;
  logic signed [W-1:0]      sum2_q;
  logic                     junc2_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[ST_PID]) begin
      err2_q  <= err_c;
      diff2_q <= diff_c;
      sum2_q  <= sum_sat;
      junc2_q <= junc_c;
    end
  end

  // Stage 3: integral magnitude, limited before the product.
  logic [W-1:0]       mag_c;
  logic [MagW-1:0]    mag_ext;
  logic [CLAMP_W-1:0] mag_cl;

  assign mag_c   = sum2_q[W-1] ? (~sum2_q + 1'b1) : sum2_q;
  assign mag_ext = MagW'(mag_c);
  assign mag_cl  = (mag_ext > MagW'(CLAMP_MAG)) ? CLAMP_MAG : mag_ext[CLAMP_W-1:0];

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[ST_MAG]) begin
      err_o      <= err2_q;
      diff_o     <= diff2_q;
      mag_o      <= mag_cl;
      neg_o      <= sum2_q[W-1];
      junction_o <= junc2_q;
    end
  end

endmodule

>>> sv/lfs_mul.sv
// Gain product stage and integral term assembly stage.
module lfs_mul (
  input  logic                                 clk_i,
  input  lfs_pkg::lfs_pipe_t                   pipe_i,
  input  lfs_pkg::lfs_cfg_t                    cfg_i,
  input  logic signed [lfs_pkg::ERR_W-1:0]     err_i,
  input  logic signed [lfs_pkg::DIFF_W-1:0]    diff_i,
  input  logic [lfs_pkg::CLAMP_W-1:0]          mag_i,
  input  logic                                 neg_i,
  input  logic                                 junction_i,
  output logic signed [lfs_pkg::TOTAL_W-1:0]   integ_term_o,
  output logic signed [lfs_pkg::PROP_W-1:0]    prop_o,
  output logic signed [lfs_pkg::DERIV_W-1:0]   deriv_o,
  output logic                                 junction_o
);
  import lfs_pkg::*;

  // Stage 4: three products, the integral one in two halves.
  logic signed [PROP_W-1:0]  prop_c;
  logic signed [DERIV_W-1:0] deriv_c;
  logic [LO_W-1:0]           lo_c;
  logic [HI_W-1:0]           hi_c;

  assign prop_c  = $signed({1'b0, cfg_i.gain_prop}) * err_i;
  assign deriv_c = $signed({1'b0, cfg_i.gain_deriv}) * diff_i;
  assign lo_c    = cfg_i.gain_integ * mag_i[SPLIT_W-1:0];
  assign hi_c    = cfg_i.gain_integ * mag_i[CLAMP_W-1:SPLIT_W];

  logic signed [PROP_W-1:0]  prop4_q;
  logic signed [DERIV_W-1:0] deriv4_q;
  logic [LO_W-1:0]           lo4_q;
  logic [HI_W-1:0]           hi4_q;
  logic                      neg4_q;
  logic                      junc4_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[ST_MUL]) begin
      prop4_q  <= prop_c;
      deriv4_q <= deriv_c;
      lo4_q    <= lo_c;
      hi4_q    <= hi_c;
      neg4_q   <= neg_i;
      junc4_q  <= junction_i;
    end
  end

  // Stage 5: recombine the halves and restore the sign.
  logic [IMAG_W-1:0]          imag_c;
  logic signed [TOTAL_W-1:0]  iterm_c;

  assign imag_c  = {hi4_q, {SPLIT_W{1'b0}}} + IMAG_W'(lo4_q);
  assign iterm_c = neg4_q ? -$signed({1'b0, imag_c}) : $signed({1'b0, imag_c});

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[ST_TERM]) begin
      integ_term_o <= iterm_c;
      prop_o       <= prop4_q;
      deriv_o      <= deriv4_q;
      junction_o   <= junc4_q;
    end
  end

endmodule

>>> sv/lfs_out.sv
// Correction sum, scaling and drive saturation stages.
module lfs_out (
  input  logic                                 clk_i,
  input  lfs_pkg::lfs_pipe_t                   pipe_i,
  input  lfs_pkg::lfs_cfg_t                    cfg_i,
  input  logic signed [lfs_pkg::TOTAL_W-1:0]   integ_term_i,
  input  logic signed [lfs_pkg::PROP_W-1:0]    prop_i,
  input  logic signed [lfs_pkg::DERIV_W-1:0]   deriv_i,
  input  logic                                 junction_i,
  output logic signed [lfs_pkg::DRIVE_W-1:0]   drive_left_o,
  output logic signed [lfs_pkg::DRIVE_W-1:0]   drive_right_o,
  output logic                                 junction_seen_o
);
  import lfs_pkg::*;

  // Stage 6: sum of the three terms.
  logic signed [TOTAL_W-1:0] total_c;
  logic signed [TOTAL_W-1:0] total6_q;
  logic                      junc6_q;

  assign total_c = integ_term_i
                 + {{(TOTAL_W-PROP_W){prop_i[PROP_W-1]}}, prop_i}
                 + {{(TOTAL_W-DERIV_W){deriv_i[DERIV_W-1]}}, deriv_i};

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[ST_SUM]) begin
      total6_q <= total_c;
      junc6_q  <= junction_i;
    end
  end

  // Stage 7: drop the fraction toward zero and limit the correction.
  logic signed [TOTAL_W-1:0] adj_c;
  logic signed [UFULL_W-1:0] ufull_c;
  logic signed [U_W-1:0]     u_c;
  logic signed [U_W-1:0]     u7_q;
  logic                      junc7_q;

  assign adj_c   = total6_q[TOTAL_W-1] ? (total6_q + 64'sd65535) : total6_q;
  assign ufull_c = adj_c[TOTAL_W-1:FRAC_W];

  always_comb begin
    priority if (ufull_c > UFULL_W'(U_LIMIT)) begin
      u_c = U_LIMIT;
    end else if (ufull_c < -UFULL_W'(U_LIMIT)) begin
      u_c = -U_LIMIT;
    end else begin
      u_c = ufull_c[U_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[ST_U]) begin
      u7_q    <= u_c;
      junc7_q <= junc6_q;
    end
  end

  // Output stage: base speed plus and minus the correction, saturated.
  logic signed [SUM_DRV_W-1:0] base_c;
  logic signed [SUM_DRV_W-1:0] left_c, right_c;
  logic signed [DRIVE_W-1:0]   left_sat, right_sat;

  assign base_c  = $signed({{(SUM_DRV_W-REFL_W){1'b0}}, cfg_i.base_speed});
  assign left_c  = base_c + {u7_q[U_W-1], u7_q};
  assign right_c = base_c - {u7_q[U_W-1], u7_q};

  always_comb begin
    priority if (left_c > DRIVE_LIMIT) begin
      left_sat = DRIVE_LIMIT[DRIVE_W-1:0];
    end else if (left_c < -DRIVE_LIMIT) begin
      left_sat = -DRIVE_LIMIT[DRIVE_W-1:0];
    end else begin
      left_sat = left_c[DRIVE_W-1:0];
    end
    priority if (right_c > DRIVE_LIMIT) begin
      right_sat = DRIVE_LIMIT[DRIVE_W-1:0];
    end else if (right_c < -DRIVE_LIMIT) begin
      right_sat = -DRIVE_LIMIT[DRIVE_W-1:0];
    end else begin
      right_sat = right_c[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[ST_OUT]) begin
      drive_left_o    <= left_sat;
      drive_right_o   <= right_sat;
      junction_seen_o <= junc7_q;
    end
  end

endmodule

>>> sv/pid_line_follower_step.sv
// Top level of the PID line follower step: pipeline control and stage modules.
//
//   Channel   Direction  Handshake              Payload
//   in        sink       in_valid_i/in_stall_o  refl_left_i, refl_middle_i, refl_right_i
//   out       source     out_valid_o/out_stall_i drive_left_o, drive_right_o, junction_seen_o
//   cfg       sink       cfg_we_i               cfg_idx_i, cfg_data_i
//
// One beat can enter every cycle while in_stall_o is low; its result moves through the stage
// registers in order, is presented from the output stage and leaves at the first unstalled edge.
// The loop state (integral and previous error) updates in the second stage, where it is read,
// so beats follow each other back to back; the gain products sit in their own stage.
// Reset clears the valid flags, the loop state and loads the register reset values.
// Each stage holds its beat while the stage after it is full and stalled, so an
// output stall fills the empty stages first before the input stalls.
`include "assert_macros.svh"

module pid_line_follower_step #(
  parameter int unsigned INTEGRAL_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lfs_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lfs_pkg::GAIN_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lfs_pkg::REFL_W-1:0]          refl_left_i,
  input  logic [lfs_pkg::REFL_W-1:0]          refl_middle_i,
  input  logic [lfs_pkg::REFL_W-1:0]          refl_right_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lfs_pkg::DRIVE_W-1:0]  drive_left_o,
  output logic signed [lfs_pkg::DRIVE_W-1:0]  drive_right_o,
  output logic                                junction_seen_o
);
  import lfs_pkg::*;

  // Pipeline control. A stage may load when it is empty or its beat moves on.
  logic [STAGES-1:0] valid_q, valid_d;
  logic [STAGES-1:0] load;
  lfs_pipe_t         pipe;

  always_comb begin
    load[STAGES-1] = !valid_q[STAGES-1] || !out_stall_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_comb begin
    valid_d[0] = load[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < STAGES; k++) begin
      valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign pipe = '{load: load, valid: valid_q};

  assign in_stall_o  = !load[ST_IN];
  assign out_valid_o = valid_q[ST_OUT];

  // Configuration registers.
  lfs_cfg_t cfg;

  lfs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Error, loop state and integral magnitude.
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic [CLAMP_W-1:0]       mag;
  logic                     neg;
  logic                     junc_front;

  lfs_front #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pipe_i        (pipe),
    .cfg_i         (cfg),
    .refl_left_i   (refl_left_i),
    .refl_middle_i (refl_middle_i),
    .refl_right_i  (refl_right_i),
    .err_o         (err),
    .diff_o        (diff),
    .mag_o         (mag),
    .neg_o         (neg),
    .junction_o    (junc_front)
  );

  // Gain products.
  logic signed [TOTAL_W-1:0] integ_term;
  logic signed [PROP_W-1:0]  prop;
  logic signed [DERIV_W-1:0] deriv;
  logic                      junc_mul;

  lfs_mul u_mul (
    .clk_i        (clk_i),
    .pipe_i       (pipe),
    .cfg_i        (cfg),
    .err_i        (err),
    .diff_i       (diff),
    .mag_i        (mag),
    .neg_i        (neg),
    .junction_i   (junc_front),
    .integ_term_o (integ_term),
    .prop_o       (prop),
    .deriv_o      (deriv),
    .junction_o   (junc_mul)
  );

  // Correction and drive outputs.
  lfs_out u_out (
    .clk_i           (clk_i),
    .pipe_i          (pipe),
    .cfg_i           (cfg),
    .integ_term_i    (integ_term),
    .prop_i          (prop),
    .deriv_i         (deriv),
    .junction_i      (junc_mul),
    .drive_left_o    (drive_left_o),
    .drive_right_o   (drive_right_o),
    .junction_seen_o (junction_seen_o)
  );

  // Either drive lies outside the saturation band.
  logic drive_bad;

  assign drive_bad = (drive_left_o > 8'sd100) || (drive_left_o < -8'sd100)
                  || (drive_right_o > 8'sd100) || (drive_right_o < -8'sd100);

  // An empty input stage never pushes back on the source.
  `LFS_ASSERT(a_in_free, clk_i, rst_ni, !valid_q[ST_IN] |-> !in_stall_o, "stall while empty")
  // A new result only appears when the stage before held a beat.
  `LFS_ASSERT(a_out_source, clk_i, rst_ni, $rose(out_valid_o) |-> $past(valid_q[ST_U]), "orphan")
  // Both drives stay inside the saturation band.
  `LFS_ASSERT_NEVER(a_drive_range, clk_i, rst_ni, out_valid_o && drive_bad, "drive out of band")

endmodule
